// ===== rtl/core/ll1_pkg.sv =====
package ll1_pkg;

    localparam logic [7:0] CH_END  = 8'h24;
    localparam logic [7:0] CH_ID   = 8'h69;
    localparam logic [7:0] CH_PLUS = 8'h2B;
    localparam logic [7:0] CH_STAR = 8'h2A;
    localparam logic [7:0] CH_LP   = 8'h28;
    localparam logic [7:0] CH_RP   = 8'h29;

    typedef enum logic [3:0] {
        SY_END  = 4'd0,
        SY_E    = 4'd1,
        SY_EP   = 4'd2,
        SY_T    = 4'd3,
        SY_TP   = 4'd4,
        SY_F    = 4'd5,
        SY_ID   = 4'd6,
        SY_PLUS = 4'd7,
        SY_STAR = 4'd8,
        SY_LP   = 4'd9,
        SY_RP   = 4'd10
    } sym_t;

    typedef enum logic [1:0] {
        ST_PENDING  = 2'd0,
        ST_ACCEPT   = 2'd1,
        ST_ERROR    = 2'd2,
        ST_OVERFLOW = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        RU_E,
        RU_EP,
        RU_T,
        RU_TP,
        RU_FI,
        RU_FP
    } rule_t;

    typedef enum logic [1:0] {
        OFF_ZERO,
        OFF_CHAR,
        OFF_TOPCH
    } off_sel_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_PUSH,
        S_FETCH,
        S_MATCH
    } state_t;

    typedef enum logic [1:0] {
        ACT_FINISH,
        ACT_EXPAND,
        ACT_POP,
        ACT_MATCH
    } act_t;

    typedef struct packed {
        logic     load_char;
        logic     expand;
        rule_t    rule;
        logic     push_w1;
        logic     pop;
        logic     load_top;
        logic     reinit;
        logic     res_we;
        status_t  res_status;
        off_sel_t res_off;
    } dp_cmd_t;

    typedef struct packed {
        sym_t top;
        logic ch_is_id;
        logic ch_is_lp;
        logic ch_is_plus;
        logic ch_is_star;
        logic ch_is_end;
        logic ch_match;
        logic room1;
        logic room2;
    } dp_stat_t;

    function automatic logic [7:0] term_char(input sym_t s);
        logic [7:0] c;
        case (s)
            SY_END:  c = CH_END;
            SY_ID:   c = CH_ID;
            SY_PLUS: c = CH_PLUS;
            SY_STAR: c = CH_STAR;
            SY_LP:   c = CH_LP;
            SY_RP:   c = CH_RP;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // symbols a rule pushes, bottom first: w0, w1, then the new top
    function automatic logic [1:0] rule_len(input rule_t r);
        logic [1:0] n;
        case (r)
            RU_E:    n = 2'd2;
            RU_EP:   n = 2'd3;
            RU_T:    n = 2'd2;
            RU_TP:   n = 2'd3;
            RU_FI:   n = 2'd1;
            RU_FP:   n = 2'd3;
            default: n = 2'd1;
        endcase
        return n;
    endfunction

    function automatic sym_t rule_w0(input rule_t r);
        sym_t s;
        case (r)
            RU_E:    s = SY_EP;
            RU_EP:   s = SY_EP;
            RU_T:    s = SY_TP;
            RU_TP:   s = SY_TP;
            RU_FP:   s = SY_RP;
            default: s = SY_END;
        endcase
        return s;
    endfunction

    function automatic sym_t rule_w1(input rule_t r);
        sym_t s;
        case (r)
            RU_EP:   s = SY_T;
            RU_TP:   s = SY_F;
            RU_FP:   s = SY_E;
            default: s = SY_END;
        endcase
        return s;
    endfunction

    function automatic sym_t rule_top(input rule_t r);
        sym_t s;
        case (r)
            RU_E:    s = SY_T;
            RU_EP:   s = SY_PLUS;
            RU_T:    s = SY_F;
            RU_TP:   s = SY_STAR;
            RU_FI:   s = SY_ID;
            RU_FP:   s = SY_LP;
            default: s = SY_END;
        endcase
        return s;
    endfunction

endpackage

// ===== rtl/core/ll1_ctrl.sv =====
module ll1_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  ll1_pkg::dp_stat_t stat,
    output ll1_pkg::dp_cmd_t  cmd
);

    ll1_pkg::state_t  state_reg;
    ll1_pkg::state_t  state_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             slot_free;
    logic             first;
    logic             overflow;
    logic [1:0]       len;
    ll1_pkg::act_t    act;
    ll1_pkg::rule_t   rule;
    ll1_pkg::status_t fin_status;
    ll1_pkg::off_sel_t fin_off;

    assign slot_free = !out_valid_reg || out_ready;
    assign first     = stat.ch_is_id || stat.ch_is_lp;
    assign len       = ll1_pkg::rule_len(rule);
    assign overflow  = (len == 2'd3 && !stat.room2) || (len == 2'd2 && !stat.room1);
    assign out_valid = out_valid_reg;

    // decode of the top symbol against the current character
    always_comb
    begin
        act        = ll1_pkg::ACT_FINISH;
        rule       = ll1_pkg::RU_E;
        fin_status = ll1_pkg::ST_ERROR;
        fin_off    = ll1_pkg::OFF_ZERO;
        case (stat.top)
            ll1_pkg::SY_END:
            begin
                if (stat.ch_is_end)
                    fin_status = ll1_pkg::ST_ACCEPT;
                else
                    fin_off = ll1_pkg::OFF_TOPCH;
            end
            ll1_pkg::SY_ID, ll1_pkg::SY_PLUS, ll1_pkg::SY_STAR,
            ll1_pkg::SY_LP, ll1_pkg::SY_RP:
            begin
                if (stat.ch_match)
                    act = ll1_pkg::ACT_MATCH;
                else
                    fin_off = ll1_pkg::OFF_TOPCH;
            end
            ll1_pkg::SY_E:
            begin
                if (first)
                begin
                    act  = ll1_pkg::ACT_EXPAND;
                    rule = ll1_pkg::RU_E;
                end
                else
                    fin_off = ll1_pkg::OFF_CHAR;
            end
            ll1_pkg::SY_T:
            begin
                if (first)
                begin
                    act  = ll1_pkg::ACT_EXPAND;
                    rule = ll1_pkg::RU_T;
                end
                else
                    fin_off = ll1_pkg::OFF_CHAR;
            end
            ll1_pkg::SY_EP:
            begin
                if (stat.ch_is_plus)
                begin
                    act  = ll1_pkg::ACT_EXPAND;
                    rule = ll1_pkg::RU_EP;
                end
                else
                    act = ll1_pkg::ACT_POP;
            end
            ll1_pkg::SY_TP:
            begin
                if (stat.ch_is_star)
                begin
                    act  = ll1_pkg::ACT_EXPAND;
                    rule = ll1_pkg::RU_TP;
                end
                else
                    act = ll1_pkg::ACT_POP;
            end
            ll1_pkg::SY_F:
            begin
                if (stat.ch_is_id)
                begin
                    act  = ll1_pkg::ACT_EXPAND;
                    rule = ll1_pkg::RU_FI;
                end
                else if (stat.ch_is_lp)
                begin
                    act  = ll1_pkg::ACT_EXPAND;
                    rule = ll1_pkg::RU_FP;
                end
                else
                    fin_off = ll1_pkg::OFF_CHAR;
            end
            default:
            begin
                fin_off = ll1_pkg::OFF_ZERO;
            end
        endcase
        if (act == ll1_pkg::ACT_EXPAND && overflow)
        begin
            act        = ll1_pkg::ACT_FINISH;
            fin_status = ll1_pkg::ST_OVERFLOW;
            fin_off    = ll1_pkg::OFF_CHAR;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ll1_pkg::S_IDLE:
            begin
                if (in_valid)
                    state_next = ll1_pkg::S_EVAL;
            end
            ll1_pkg::S_EVAL:
            begin
                case (act)
                    ll1_pkg::ACT_FINISH:
                    begin
                        if (slot_free)
                            state_next = ll1_pkg::S_IDLE;
                    end
                    ll1_pkg::ACT_EXPAND:
                    begin
                        if (len == 2'd3)
                            state_next = ll1_pkg::S_PUSH;
                    end
                    ll1_pkg::ACT_POP:   state_next = ll1_pkg::S_FETCH;
                    ll1_pkg::ACT_MATCH: state_next = ll1_pkg::S_MATCH;
                    default:            state_next = ll1_pkg::S_EVAL;
                endcase
            end
            ll1_pkg::S_PUSH:  state_next = ll1_pkg::S_EVAL;
            ll1_pkg::S_FETCH: state_next = ll1_pkg::S_EVAL;
            ll1_pkg::S_MATCH:
            begin
                if (slot_free)
                    state_next = ll1_pkg::S_IDLE;
            end
            default: state_next = ll1_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready       = 1'b0;
        cmd.load_char  = 1'b0;
        cmd.expand     = 1'b0;
        cmd.rule       = rule;
        cmd.push_w1    = 1'b0;
        cmd.pop        = 1'b0;
        cmd.load_top   = 1'b0;
        cmd.reinit     = 1'b0;
        cmd.res_we     = 1'b0;
        cmd.res_status = fin_status;
        cmd.res_off    = fin_off;
        case (state_reg)
            ll1_pkg::S_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.load_char = in_valid;
            end
            ll1_pkg::S_EVAL:
            begin
                case (act)
                    ll1_pkg::ACT_FINISH:
                    begin
                        cmd.res_we = slot_free;
                        cmd.reinit = slot_free;
                    end
                    ll1_pkg::ACT_EXPAND: cmd.expand = 1'b1;
                    ll1_pkg::ACT_POP:    cmd.pop    = 1'b1;
                    ll1_pkg::ACT_MATCH:  cmd.pop    = 1'b1;
                    default:             cmd.pop    = 1'b0;
                endcase
            end
            ll1_pkg::S_PUSH:  cmd.push_w1  = 1'b1;
            ll1_pkg::S_FETCH: cmd.load_top = 1'b1;
            ll1_pkg::S_MATCH:
            begin
                cmd.load_top   = 1'b1;
                cmd.res_we     = slot_free;
                cmd.res_status = ll1_pkg::ST_PENDING;
                cmd.res_off    = ll1_pkg::OFF_ZERO;
            end
            default: in_ready = 1'b0;
        endcase
    end

    assign out_valid_next = cmd.res_we ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ll1_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef ASSERT_OFF
    a_accept_to_eval: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg == ll1_pkg::S_EVAL)
        else $error("accepted beat did not start evaluation");

    a_result_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.res_we |-> !out_valid_reg || out_ready)
        else $error("result written over an untaken beat");
`endif

endmodule

// ===== rtl/core/ll1_dp.sv =====
module ll1_dp #(
    parameter int STACK_DEPTH = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [7:0]        symbol,
    input  ll1_pkg::dp_cmd_t  cmd,
    output ll1_pkg::dp_stat_t stat,
    output logic [1:0]        status,
    output logic [7:0]        offending_symbol
);

    localparam int SPW = $clog2(STACK_DEPTH);
    localparam logic [SPW:0] DEPTH_W = (SPW + 1)'(STACK_DEPTH);

    logic [3:0]     mem [STACK_DEPTH];
    logic [7:0]     char_reg;
    logic [SPW-1:0] sp_reg;
    logic [SPW-1:0] sp_next;
    ll1_pkg::sym_t  top_reg;
    ll1_pkg::sym_t  top_next;
    ll1_pkg::sym_t  pend_reg;
    logic [3:0]     rd_data_reg;
    logic           rd_zero_reg;
    logic [1:0]     status_reg;
    logic [7:0]     off_reg;
    logic [7:0]     off_next;
    logic [7:0]     top_char;
    logic [SPW-1:0] sp_dec;
    logic [1:0]     len;
    logic           wr_en;
    logic [SPW-1:0] wr_addr;
    logic [3:0]     wr_data;

    assign top_char = ll1_pkg::term_char(top_reg);
    assign sp_dec   = sp_reg - SPW'(1);
    assign len      = ll1_pkg::rule_len(cmd.rule);

    assign stat.top        = top_reg;
    assign stat.ch_is_id   = char_reg == ll1_pkg::CH_ID;
    assign stat.ch_is_lp   = char_reg == ll1_pkg::CH_LP;
    assign stat.ch_is_plus = char_reg == ll1_pkg::CH_PLUS;
    assign stat.ch_is_star = char_reg == ll1_pkg::CH_STAR;
    assign stat.ch_is_end  = char_reg == ll1_pkg::CH_END;
    assign stat.ch_match   = char_reg == top_char;
    assign stat.room1      = ({1'b0, sp_reg} + (SPW + 1)'(1)) < DEPTH_W;
    assign stat.room2      = ({1'b0, sp_reg} + (SPW + 1)'(2)) < DEPTH_W;

    // single write port: bottom symbol of an expansion, or the pending middle one
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = sp_reg;
        wr_data = ll1_pkg::rule_w0(cmd.rule);
        if (cmd.expand && len != 2'd1)
            wr_en = 1'b1;
        else if (cmd.push_w1)
        begin
            wr_en   = 1'b1;
            wr_addr = sp_dec;
            wr_data = pend_reg;
        end
    end

    always_comb
    begin
        sp_next  = sp_reg;
        top_next = top_reg;
        if (cmd.reinit)
        begin
            sp_next  = SPW'(1);
            top_next = ll1_pkg::SY_E;
        end
        else if (cmd.expand)
        begin
            sp_next  = sp_reg + SPW'(len - 2'd1);
            top_next = ll1_pkg::rule_top(cmd.rule);
        end
        else if (cmd.pop)
            sp_next = sp_dec;
        else if (cmd.load_top)
            top_next = rd_zero_reg ? ll1_pkg::SY_END : ll1_pkg::sym_t'(rd_data_reg);
    end

    always_comb
    begin
        case (cmd.res_off)
            ll1_pkg::OFF_CHAR:  off_next = char_reg;
            ll1_pkg::OFF_TOPCH: off_next = top_char;
            default:            off_next = 8'h00;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg  <= SPW'(1);
            top_reg <= ll1_pkg::SY_E;
        end
        else
        begin
            sp_reg  <= sp_next;
            top_reg <= top_next;
        end
    end

    // entry 0 is never written and always reads as the end mark
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (cmd.pop)
        begin
            rd_data_reg <= mem[sp_dec];
            rd_zero_reg <= sp_dec == '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_char)
            char_reg <= symbol;
        if (cmd.expand)
            pend_reg <= ll1_pkg::rule_w1(cmd.rule);
        if (cmd.res_we)
        begin
            status_reg <= cmd.res_status;
            off_reg    <= off_next;
        end
    end

    assign status           = status_reg;
    assign offending_symbol = off_reg;

`ifndef ASSERT_OFF
    a_reinit_stack: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.reinit |=> sp_reg == SPW'(1) && top_reg == ll1_pkg::SY_E)
        else $error("stack not restored after final beat");

    a_bottom_untouched: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> wr_addr != '0)
        else $error("write to stack bottom");
`endif

endmodule

// ===== rtl/core/ll1_expression_syntax_checker.sv =====
// LL(1) checker for the grammar E->TE', E'->+TE'|e, T->FT', T'->*FT'|e, F->(E)|i.
// Each input beat carries one character and returns one result beat: 0 pending,
// 1 accepted (on '$' with only the end mark left), 2 syntax error, 3 stack
// overflow, with the offending character or expected terminal. After 1, 2 or 3
// the stack restarts as "$ E". A character is taken in S_IDLE; each stack step
// then runs in S_EVAL, where a one- or two-symbol expansion ends; a three-symbol
// expansion adds S_PUSH, an empty-rule pop S_FETCH, the final match S_MATCH, and
// accept or error ends in S_EVAL. A finished result waits while the last one is
// not yet taken by out_ready. S_PUSH and S_FETCH come from the single write port
// and registered read of the STACK_DEPTH x 4 symbol stack memory.
// No clearing pass after reset: the stack bottom is implied.
module ll1_expression_syntax_checker #(
    parameter int STACK_DEPTH = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] symbol,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] status,
    output logic [7:0] offending_symbol
);

    ll1_pkg::dp_cmd_t  cmd;
    ll1_pkg::dp_stat_t stat;

    ll1_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    ll1_dp #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .symbol           (symbol),
        .cmd              (cmd),
        .stat             (stat),
        .status           (status),
        .offending_symbol (offending_symbol)
    );

endmodule
